FILE: hdl/spgpm_pkg.sv
// shared types, constants and the pan factor table for the stereo pan/gain meter
`default_nettype none

package spgpm_pkg;

	// field widths
	localparam int SAMPLE_W    = 32;
	localparam int VOL_W       = 7;
	localparam int PAN_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	// default parameter values
	localparam int FRAC_BITS_DEF    = 16;
	localparam int BLOCK_PAIRS_DEF  = 64;
	localparam int METER_STRIDE_DEF = 4;

	// pan factor format (Q30) and table geometry
	localparam int FACTOR_FRAC = 30;
	localparam int FACTOR_W    = 31;
	localparam int ROM_DEPTH   = 201;
	localparam int ROM_IDX_W   = $clog2(ROM_DEPTH);

	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] SQRT2_Q30   = 64'd1518500250;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// gain = volume / VOL_SCALE times pan factor
	localparam int VOL_SCALE = 100;
	localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(100);
	localparam logic [ROM_IDX_W-1:0] PAN_CENTER = ROM_IDX_W'(100);
	localparam logic signed [PAN_W-1:0] PAN_HI = 8'sd100;
	localparam logic signed [PAN_W-1:0] PAN_LO = -8'sd100;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VOLUME = 2'd0,
		CFG_PAN    = 2'd1,
		CFG_MUTED  = 2'd2
	} cfg_idx_t;

	// configuration register set
	typedef struct packed {
		logic [VOL_W-1:0]        volume;
		logic signed [PAN_W-1:0] pan;
		logic                    muted;
	} cfg_t;

	// pipeline load and state-step enables
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic step;
	} pipe_ctl_t;

	typedef logic [FACTOR_W-1:0] pan_rom_t [ROM_DEPTH];

	// sqrt2*cos(k*pi/400) in Q30, cosine by a 13-term truncated taylor series clamped to [0,1]
	function automatic pan_rom_t build_pan_rom();
		pan_rom_t    rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			x    = (64'(k) * HALF_PI_Q30) / 64'd200;
			x2   = (x * x) >> FACTOR_FRAC;
			term = ONE_Q30;
			sum  = longint'(ONE_Q30);
			for (int n = 1; n <= 12; n++) begin
				term = ((term * x2) >> FACTOR_FRAC) / 64'((2 * n - 1) * (2 * n));
				if ((n % 2) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > longint'(ONE_Q30)) begin
				sum = longint'(ONE_Q30);
			end
			rom[k] = FACTOR_W'((64'(sum) * SQRT2_Q30) >> FACTOR_FRAC);
		end
		return rom;
	endfunction

	localparam pan_rom_t PAN_ROM = build_pan_rom();

endpackage

`default_nettype wire

FILE: hdl/spgpm_cfg.sv
// configuration registers: volume, clamped pan and mute
`default_nettype none

module spgpm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spgpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spgpm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              busy,
	output logic                              wr,
	output spgpm_pkg::cfg_t                   cfg
);
	import spgpm_pkg::*;

	cfg_t                    cfg_q;
	logic signed [PAN_W-1:0] pan_raw;
	logic signed [PAN_W-1:0] pan_clamped;

	// writes wait while the gain unit recomputes
	assign cfg_ready = !busy;
	assign wr        = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	// pan saturates to the hard left / hard right limits
	assign pan_raw = signed'(cfg_data[PAN_W-1:0]);
	always_comb begin
		if (pan_raw < PAN_LO) begin
			pan_clamped = PAN_LO;
		end else if (pan_raw > PAN_HI) begin
			pan_clamped = PAN_HI;
		end else begin
			pan_clamped = pan_raw;
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume <= VOL_RESET;
			cfg_q.pan    <= '0;
			cfg_q.muted  <= 1'b0;
		end else if (wr) begin
			unique case (cfg_index)
				CFG_VOLUME: cfg_q.volume <= cfg_data[VOL_W-1:0];
				CFG_PAN:    cfg_q.pan    <= pan_clamped;
				CFG_MUTED:  cfg_q.muted  <= cfg_data[0];
				default:    ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/spgpm_gain.sv
// gain unit: pan table lookup, volume multiply and a reciprocal divide by the gain scale
`default_nettype none

module spgpm_gain #(
	parameter int FRAC_BITS = spgpm_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spgpm_pkg::cfg_t   cfg,
	input  logic              start,
	output logic              busy,
	output logic [FRAC_BITS:0] gain_l,
	output logic [FRAC_BITS:0] gain_r
);
	import spgpm_pkg::*;

	localparam int GW  = FRAC_BITS + 1;
	localparam int PW  = VOL_W + FACTOR_W;
	// the factor of four in the scale joins the Q30 to FRAC_BITS shift
	localparam int QSH = FACTOR_FRAC - FRAC_BITS + 2;
	localparam int XW  = PW - QSH;
	// odd part of the scale by reciprocal multiply, exact for every shifted product
	localparam int RSH = 35;
	localparam int RW  = 31;
	localparam int QW  = XW + RW;
	localparam logic [63:0]   VOL_ODD = 64'(VOL_SCALE / 4);
	localparam logic [RW-1:0] RECIP   = RW'(((64'd1 << RSH) + VOL_ODD - 64'd1) / VOL_ODD);

	typedef enum logic [3:0] {
		G_IDLE   = 4'b0001,
		G_LOOKUP = 4'b0010,
		G_MULT   = 4'b0100,
		G_DIV    = 4'b1000
	} gstate_t;

	gstate_t              state_q;
	logic [FACTOR_W-1:0]  fl_q;
	logic [FACTOR_W-1:0]  fr_q;
	logic [PW-1:0]        prod_l_q;
	logic [PW-1:0]        prod_r_q;
	logic [GW-1:0]        gain_l_q;
	logic [GW-1:0]        gain_r_q;
	logic [ROM_IDX_W-1:0] k_l;
	logic [ROM_IDX_W-1:0] k_r;
	logic [QW-1:0]        quo_l;
	logic [QW-1:0]        quo_r;

	assign busy   = (state_q != G_IDLE);
	assign gain_l = gain_l_q;
	assign gain_r = gain_r_q;

	// table index: left uses pan+100, right uses 100-pan
	assign k_l = PAN_CENTER + ROM_IDX_W'(cfg.pan);
	assign k_r = PAN_CENTER - ROM_IDX_W'(cfg.pan);

	// shifted product times the reciprocal of the odd scale part
	assign quo_l = QW'(prod_l_q[PW-1:QSH]) * QW'(RECIP);
	assign quo_r = QW'(prod_r_q[PW-1:QSH]) * QW'(RECIP);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
		end else begin
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						state_q <= G_LOOKUP;
					end
				end
				G_LOOKUP: state_q <= G_MULT;
				G_MULT:   state_q <= G_DIV;
				G_DIV:    state_q <= G_IDLE;
				default:  state_q <= G_IDLE;
			endcase
		end
	end

	// gains reset to unity, the value for volume 100 at center pan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_l_q <= GW'(1) << FRAC_BITS;
			gain_r_q <= GW'(1) << FRAC_BITS;
		end else if (state_q == G_DIV) begin
			gain_l_q <= quo_l[RSH+GW-1:RSH];
			gain_r_q <= quo_r[RSH+GW-1:RSH];
		end
	end

	// datapath: factor lookup and volume product
	always_ff @(posedge clk) begin
		unique case (state_q)
			G_LOOKUP: begin
				if (cfg.pan == '0) begin
					fl_q <= FACTOR_W'(ONE_Q30);
					fr_q <= FACTOR_W'(ONE_Q30);
				end else begin
					fl_q <= PAN_ROM[k_l];
					fr_q <= PAN_ROM[k_r];
				end
			end
			G_MULT: begin
				prod_l_q <= PW'(cfg.volume) * PW'(fl_q);
				prod_r_q <= PW'(cfg.volume) * PW'(fr_q);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/spgpm_scale.sv
// input register and gain multiply stage
`default_nettype none

module spgpm_scale #(
	parameter int FRAC_BITS = spgpm_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  spgpm_pkg::pipe_ctl_t                   ctl,
	input  spgpm_pkg::cfg_t                        cfg,
	input  logic [FRAC_BITS:0]                     gain_l,
	input  logic [FRAC_BITS:0]                     gain_r,
	input  logic signed [spgpm_pkg::SAMPLE_W-1:0]  left_in,
	input  logic signed [spgpm_pkg::SAMPLE_W-1:0]  right_in,
	input  logic                                   source_active,
	input  logic                                   last_of_buffer,
	output logic signed [spgpm_pkg::SAMPLE_W-1:0]  left_s2,
	output logic signed [spgpm_pkg::SAMPLE_W-1:0]  right_s2,
	output logic                                   audible_s2,
	output logic                                   last_s2
);
	import spgpm_pkg::*;

	localparam int GW = FRAC_BITS + 1;

	logic signed [SAMPLE_W-1:0]  left_s1;
	logic signed [SAMPLE_W-1:0]  right_s1;
	logic                        active_s1;
	logic                        last_s1;
	logic                        audible;
	logic signed [SAMPLE_W+GW:0] prod_l;
	logic signed [SAMPLE_W+GW:0] prod_r;

	// input register
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			left_s1   <= left_in;
			right_s1  <= right_in;
			active_s1 <= source_active;
			last_s1   <= last_of_buffer;
		end
	end

	assign audible = active_s1 && !cfg.muted && (cfg.volume != '0);

	// signed sample times unsigned gain, arithmetic shift by the fraction bits
	assign prod_l = left_s1 * $signed({1'b0, gain_l});
	assign prod_r = right_s1 * $signed({1'b0, gain_r});

	// scaled or passed-through samples
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			left_s2    <= audible ? prod_l[FRAC_BITS+SAMPLE_W-1:FRAC_BITS] : left_s1;
			right_s2   <= audible ? prod_r[FRAC_BITS+SAMPLE_W-1:FRAC_BITS] : right_s1;
			audible_s2 <= audible;
			last_s2    <= last_s1;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/spgpm_meter.sv
// block peak meter with decay and the result register
`default_nettype none

module spgpm_meter #(
	parameter int BLOCK_PAIRS  = spgpm_pkg::BLOCK_PAIRS_DEF,
	parameter int METER_STRIDE = spgpm_pkg::METER_STRIDE_DEF,
	parameter int FRAC_BITS    = spgpm_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  spgpm_pkg::pipe_ctl_t                   ctl,
	input  logic signed [spgpm_pkg::SAMPLE_W-1:0]  left_s2,
	input  logic signed [spgpm_pkg::SAMPLE_W-1:0]  right_s2,
	input  logic                                   audible_s2,
	input  logic                                   last_s2,
	output logic signed [spgpm_pkg::SAMPLE_W-1:0]  left_s3,
	output logic signed [spgpm_pkg::SAMPLE_W-1:0]  right_s3,
	output logic                                   audible_s3,
	output logic [spgpm_pkg::SAMPLE_W-1:0]         meter_left_s3,
	output logic [spgpm_pkg::SAMPLE_W-1:0]         meter_right_s3
);
	import spgpm_pkg::*;

	localparam int PW = $clog2(BLOCK_PAIRS);
	localparam int SW = (METER_STRIDE > 1) ? $clog2(METER_STRIDE) : 1;
	// half peak * 1000 below 65534 * 2^FRAC_BITS floors to zero
	localparam logic [63:0] FLOOR_LIM = ((64'd65534 << FRAC_BITS) + 64'd999) / 64'd1000;

	logic [SAMPLE_W-1:0] held_l_q;
	logic [SAMPLE_W-1:0] held_r_q;
	logic [SAMPLE_W-1:0] bmax_l_q;
	logic [SAMPLE_W-1:0] bmax_r_q;
	logic [PW-1:0]       pos_q;
	logic [SW-1:0]       stride_q;

	logic [SAMPLE_W-1:0] mag_l;
	logic [SAMPLE_W-1:0] mag_r;
	logic                take;
	logic                close;
	logic [SAMPLE_W-1:0] bmax_l_n;
	logic [SAMPLE_W-1:0] bmax_r_n;
	logic [SAMPLE_W-1:0] half_l;
	logic [SAMPLE_W-1:0] half_r;
	logic [SAMPLE_W-1:0] held_l_n;
	logic [SAMPLE_W-1:0] held_r_n;
	logic [SAMPLE_W-1:0] meter_l;
	logic [SAMPLE_W-1:0] meter_r;

	// magnitudes of the scaled samples
	assign mag_l = left_s2[SAMPLE_W-1]  ? SAMPLE_W'(0) - SAMPLE_W'(left_s2)  : SAMPLE_W'(left_s2);
	assign mag_r = right_s2[SAMPLE_W-1] ? SAMPLE_W'(0) - SAMPLE_W'(right_s2) : SAMPLE_W'(right_s2);

	// block maximum over every stride-th pair of the block, audible pairs only
	assign take     = audible_s2 && (stride_q == '0);
	assign bmax_l_n = (take && (mag_l > bmax_l_q)) ? mag_l : bmax_l_q;
	assign bmax_r_n = (take && (mag_r > bmax_r_q)) ? mag_r : bmax_r_q;

	// block close: take the larger block peak, else halve with a floor to zero
	assign close  = last_s2 || (pos_q == PW'(BLOCK_PAIRS - 1));
	assign half_l = held_l_q >> 1;
	assign half_r = held_r_q >> 1;
	always_comb begin
		if (bmax_l_n > held_l_q) begin
			held_l_n = bmax_l_n;
		end else if (64'(half_l) < FLOOR_LIM) begin
			held_l_n = '0;
		end else begin
			held_l_n = half_l;
		end
		if (bmax_r_n > held_r_q) begin
			held_r_n = bmax_r_n;
		end else if (64'(half_r) < FLOOR_LIM) begin
			held_r_n = '0;
		end else begin
			held_r_n = half_r;
		end
	end

	assign meter_l = close ? held_l_n : held_l_q;
	assign meter_r = close ? held_r_n : held_r_q;

	// meter state, advanced once per word moved into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_l_q <= '0;
			held_r_q <= '0;
			bmax_l_q <= '0;
			bmax_r_q <= '0;
			pos_q    <= '0;
			stride_q <= '0;
		end else if (ctl.step) begin
			if (close) begin
				held_l_q <= held_l_n;
				held_r_q <= held_r_n;
				bmax_l_q <= '0;
				bmax_r_q <= '0;
				pos_q    <= '0;
				stride_q <= '0;
			end else begin
				bmax_l_q <= bmax_l_n;
				bmax_r_q <= bmax_r_n;
				pos_q    <= pos_q + 1'b1;
				if (stride_q == SW'(METER_STRIDE - 1)) begin
					stride_q <= '0;
				end else begin
					stride_q <= stride_q + 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			left_s3        <= left_s2;
			right_s3       <= right_s2;
			audible_s3     <= audible_s2;
			meter_left_s3  <= meter_l;
			meter_right_s3 <= meter_r;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/stereo_pan_gain_peak_meter.sv
// top level: stereo pan/gain stage with block peak meter
//
// channel | dir | handshake           | contents
// s_*     | in  | s_tvalid / s_tready | tdata left/right pair, tuser source active, tlast buffer end
// m_*     | out | m_tvalid / m_tready | tdata scaled pair and held peaks, tuser audible
// cfg_*   | in  | cfg_valid/cfg_ready | register index and write data
//
// one pair per cycle sustained while m_tready is high and the gain unit is not busy; each word
// passes the input register, multiply register and result register; stages close bubbles on stall
// a configuration write starts the gain unit: table lookup, volume multiply and a
// reciprocal divide, with s_tready and cfg_ready low until it finishes
// reset sets volume 100, pan 0, unmuted, unity gains and clears the meter
`default_nettype none

module stereo_pan_gain_peak_meter #(
	parameter int BLOCK_PAIRS  = spgpm_pkg::BLOCK_PAIRS_DEF,
	parameter int METER_STRIDE = spgpm_pkg::METER_STRIDE_DEF,
	parameter int FRAC_BITS    = spgpm_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [2*spgpm_pkg::SAMPLE_W-1:0]      s_tdata,   // left_in, right_in
	input  logic                                  s_tuser,   // source_active
	input  logic                                  s_tlast,   // last_of_buffer
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [4*spgpm_pkg::SAMPLE_W-1:0]      m_tdata,   // left_out, right_out, meter_left, meter_right
	output logic                                  m_tuser,   // audible
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [spgpm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spgpm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import spgpm_pkg::*;

	cfg_t                       cfg;
	pipe_ctl_t                  ctl;
	logic                       cfg_wr;
	logic                       busy;
	logic [FRAC_BITS:0]         gain_l;
	logic [FRAC_BITS:0]         gain_r;
	logic                       s1_v_q;
	logic                       s2_v_q;
	logic                       s3_v_q;
	logic                       adv_s1;
	logic                       adv_s2;
	logic                       adv_s3;
	logic signed [SAMPLE_W-1:0] left_s2;
	logic signed [SAMPLE_W-1:0] right_s2;
	logic                       audible_s2;
	logic                       last_s2;
	logic signed [SAMPLE_W-1:0] left_s3;
	logic signed [SAMPLE_W-1:0] right_s3;
	logic                       audible_s3;
	logic [SAMPLE_W-1:0]        meter_left_s3;
	logic [SAMPLE_W-1:0]        meter_right_s3;

	// a stage moves when it is empty or the next one moves
	assign adv_s3   = !s3_v_q || m_tready;
	assign adv_s2   = !s2_v_q || adv_s3;
	assign adv_s1   = !s1_v_q || adv_s2;
	assign s_tready = adv_s1 && !busy;

	assign ctl.ld_s1 = adv_s1;
	assign ctl.ld_s2 = adv_s2;
	assign ctl.ld_s3 = adv_s3;
	assign ctl.step  = s2_v_q && adv_s3;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
			s3_v_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				s1_v_q <= s_tvalid && s_tready;
			end
			if (adv_s2) begin
				s2_v_q <= s1_v_q;
			end
			if (adv_s3) begin
				s3_v_q <= s2_v_q;
			end
		end
	end

	spgpm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.wr        (cfg_wr),
		.cfg       (cfg)
	);

	spgpm_gain #(
		.FRAC_BITS (FRAC_BITS)
	) u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.start  (cfg_wr),
		.busy   (busy),
		.gain_l (gain_l),
		.gain_r (gain_r)
	);

	spgpm_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scale (
		.clk            (clk),
		.ctl            (ctl),
		.cfg            (cfg),
		.gain_l         (gain_l),
		.gain_r         (gain_r),
		.left_in        (s_tdata[SAMPLE_W-1:0]),
		.right_in       (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.source_active  (s_tuser),
		.last_of_buffer (s_tlast),
		.left_s2        (left_s2),
		.right_s2       (right_s2),
		.audible_s2     (audible_s2),
		.last_s2        (last_s2)
	);

	spgpm_meter #(
		.BLOCK_PAIRS  (BLOCK_PAIRS),
		.METER_STRIDE (METER_STRIDE),
		.FRAC_BITS    (FRAC_BITS)
	) u_meter (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.left_s2        (left_s2),
		.right_s2       (right_s2),
		.audible_s2     (audible_s2),
		.last_s2        (last_s2),
		.left_s3        (left_s3),
		.right_s3       (right_s3),
		.audible_s3     (audible_s3),
		.meter_left_s3  (meter_left_s3),
		.meter_right_s3 (meter_right_s3)
	);

	// result word
	assign m_tvalid = s3_v_q;
	assign m_tdata  = {meter_right_s3, meter_left_s3, right_s3, left_s3};
	assign m_tuser  = audible_s3;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// testbench for the stereo pan/gain stage with block peak meter, checked against its own predictor
import spgpm_pkg::*;

typedef longint unsigned u64_t;

// one result word split into its fields
typedef struct {
	logic [31:0] left;
	logic [31:0] right;
	logic        audible;
	logic [31:0] peak_left;
	logic [31:0] peak_right;
} gained_pair_t;

// tracks gain settings and meter state, predicts and checks result words
class gain_meter_scoreboard;
	localparam int PAIRS_PER_BLOCK = 64;
	localparam int SAMPLE_STRIDE   = 4;
	localparam int FRAC            = 16;
	localparam longint unsigned UNITY_Q30    = 64'd1073741824;
	localparam longint unsigned ROOT2_Q30    = 64'd1518500250;
	localparam longint unsigned QUARTER_TURN = 64'd1686629713;
	localparam longint unsigned FLOOR_LEVEL  = 64'd65534 << FRAC;

	logic [6:0]      volume;
	int              pan;
	logic            muted;
	logic [31:0]     held_left;
	logic [31:0]     held_right;
	logic [31:0]     block_left;
	logic [31:0]     block_right;
	int              position;
	longint unsigned factor_table [201];
	gained_pair_t    expected_q [$];
	int              error_count;

	function new();
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		// sqrt2 * cos(k*pi/400) in Q30 by a truncated series
		for (int k = 0; k <= 200; k++) begin
			x    = (u64_t'(k) * QUARTER_TURN) / 64'd200;
			x2   = (x * x) >> 30;
			term = UNITY_Q30;
			sum  = longint'(UNITY_Q30);
			for (int n = 1; n <= 12; n++) begin
				term = ((term * x2) >> 30) / u64_t'((2 * n - 1) * (2 * n));
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > longint'(UNITY_Q30)) begin
				sum = longint'(UNITY_Q30);
			end
			factor_table[k] = (u64_t'(sum) * ROOT2_Q30) >> 30;
		end
		volume      = 7'd100;
		pan         = 0;
		muted       = 1'b0;
		held_left   = '0;
		held_right  = '0;
		block_left  = '0;
		block_right = '0;
		position    = 0;
		error_count = 0;
	endfunction

	// register write as accepted by the block
	function void write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		int p;
		case (idx)
			CFG_VOLUME: begin
				volume = data[6:0];
			end
			CFG_PAN: begin
				p = int'($signed(data));
				if (p < -100) begin
					p = -100;
				end
				if (p > 100) begin
					p = 100;
				end
				pan = p;
			end
			CFG_MUTED: begin
				muted = data[0];
			end
			default: begin
			end
		endcase
	endfunction

	function longint unsigned gain_for(input longint unsigned factor);
		return ((u64_t'(volume) * factor) / 64'd100) >> (30 - FRAC);
	endfunction

	// signed multiply, arithmetic shift, wrap to 32 bits
	function logic [31:0] apply_gain(input logic [31:0] raw, input longint unsigned gain);
		longint product;
		product = longint'($signed(raw)) * longint'(gain);
		return 32'(product >>> FRAC);
	endfunction

	function logic [31:0] magnitude(input logic [31:0] raw);
		return raw[31] ? (~raw) + 32'd1 : raw;
	endfunction

	// block end: larger peak replaces, otherwise halve with a floor
	function logic [31:0] close_block(input logic [31:0] held, input logic [31:0] bmax);
		logic [31:0] half;
		if (bmax > held) begin
			return bmax;
		end
		half = held >> 1;
		if (u64_t'(half) * 64'd1000 < FLOOR_LEVEL) begin
			half = '0;
		end
		return half;
	endfunction

	// accepted input word: work out its result word
	function void take_pair(input logic [31:0] left_in, input logic [31:0] right_in,
			input logic active, input logic last);
		gained_pair_t    res;
		longint unsigned fl;
		longint unsigned fr;
		logic [31:0]     ml;
		logic [31:0]     mr;
		res.left    = left_in;
		res.right   = right_in;
		res.audible = active && !muted && (volume != 0);
		if (res.audible) begin
			fl = UNITY_Q30;
			fr = UNITY_Q30;
			if (pan != 0) begin
				fl = factor_table[pan + 100];
				fr = factor_table[100 - pan];
			end
			res.left  = apply_gain(left_in, gain_for(fl));
			res.right = apply_gain(right_in, gain_for(fr));
			if (position % SAMPLE_STRIDE == 0) begin
				ml = magnitude(res.left);
				mr = magnitude(res.right);
				if (ml > block_left) begin
					block_left = ml;
				end
				if (mr > block_right) begin
					block_right = mr;
				end
			end
		end
		if (last || position >= PAIRS_PER_BLOCK - 1) begin
			held_left   = close_block(held_left, block_left);
			held_right  = close_block(held_right, block_right);
			block_left  = '0;
			block_right = '0;
			position    = 0;
		end else begin
			position++;
		end
		res.peak_left  = held_left;
		res.peak_right = held_right;
		expected_q.push_back(res);
	endfunction

	function void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			error_count++;
		end
	endfunction

	// accepted result word against the oldest prediction
	function void check_word(input gained_pair_t got);
		gained_pair_t want;
		if (expected_q.size() == 0) begin
			$error("result word with no pair outstanding: left_out %h right_out %h",
				got.left, got.right);
			error_count++;
			return;
		end
		want = expected_q.pop_front();
		compare_field("left_out", want.left, got.left);
		compare_field("right_out", want.right, got.right);
		compare_field("audible", 32'(want.audible), 32'(got.audible));
		compare_field("meter_left", want.peak_left, got.peak_left);
		compare_field("meter_right", want.peak_right, got.peak_right);
	endfunction
endclass

module testbench;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	gain_meter_scoreboard meter_sb = new();

	stereo_pan_gain_peak_meter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: random stall before each word unless rx_steady
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n && m_tvalid));
		end
	end

	// check every accepted result word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			meter_sb.check_word('{m_tdata[31:0], m_tdata[63:32], m_tuser,
				m_tdata[95:64], m_tdata[127:96]});
		end
	end

	// run limit
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// one input word, random gap before it unless tx_steady
	task automatic send_pair(input logic [31:0] left_in, input logic [31:0] right_in,
			input logic active, input logic last);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {right_in, left_in};
		s_tuser  <= active;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		meter_sb.take_pair(left_in, right_in, active, last);
	endtask

	// hold input until every predicted word has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (meter_sb.expected_q.size() != 0);
	endtask

	// one register write, then wait for the gain unit to finish
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		meter_sb.write_register(idx, data);
		cfg_valid <= 1'b0;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// sample with a random magnitude range, sometimes a full-scale extreme
	function automatic logic [31:0] rand_sample(input int shift);
		if ($urandom_range(0, 31) == 0) begin
			return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		end
		return 32'($signed($urandom()) >>> shift);
	endfunction

	// mostly whole buffers, some noise, some silent stretches for decay
	task automatic run_phase(input int target);
		int   sent;
		int   len;
		int   shift;
		int   style;
		logic active;
		sent = 0;
		while (sent < target) begin
			style = $urandom_range(0, 9);
			shift = $urandom_range(0, 24);
			if (style < 7) begin
				len    = $urandom_range(1, 140);
				active = ($urandom_range(0, 4) != 0);
			end else if (style < 9) begin
				len = $urandom_range(1, 24);
			end else begin
				len    = $urandom_range(64, 200);
				active = 1'b0;
			end
			if (len > target - sent) begin
				len = target - sent;
			end
			for (int i = 0; i < len; i++) begin
				if (style >= 7 && style < 9) begin
					send_pair(rand_sample(shift), rand_sample(shift),
						1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
				end else begin
					send_pair(rand_sample(shift), rand_sample(shift), active, i == len - 1);
				end
			end
			sent += len;
		end
	endtask

	// reset, directed words, random phases, drain
	initial begin
		logic [7:0] vol_data;
		logic [7:0] pan_data;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_VOLUME;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: center pan is exact unity gain
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
		send_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_pair(32'h0001_0000, 32'hFFFF_0000, 1'b1, 1'b0);
		send_pair(32'h1234_5678, 32'h8765_4321, 1'b0, 1'b0);
		send_pair(32'h7FFF_0000, 32'h8001_0000, 1'b1, 1'b1);
		wait_drained();

		// full volume, pan code below range clamps to hard left
		write_reg(CFG_VOLUME, 8'hFF);
		write_reg(CFG_PAN, 8'h80);
		write_reg(CFG_MUTED, 8'hFE);
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
		wait_drained();

		// pan code above range clamps to hard right
		write_reg(CFG_PAN, 8'h7F);
		send_pair(32'h4000_0000, 32'hC000_0000, 1'b1, 1'b0);
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
		wait_drained();

		// zero volume is inaudible, samples pass
		write_reg(CFG_VOLUME, 8'h00);
		send_pair(32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 1'b0);
		send_pair(32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1);
		wait_drained();

		// muted is inaudible even with volume
		write_reg(CFG_VOLUME, 8'h01);
		write_reg(CFG_MUTED, 8'h01);
		send_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0);
		send_pair(32'h0001_0000, 32'hFFFF_0000, 1'b1, 1'b1);
		wait_drained();

		// small pan offset, spare index has no effect
		write_reg(CFG_MUTED, 8'h00);
		write_reg(CFG_PAN, 8'hFF);
		write_reg(CFG_SPARE, 8'hA5);
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
		send_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0);
		send_pair(32'h3FFF_0000, 32'hC001_0000, 1'b1, 1'b1);

		// random phases with new settings, drained before each
		for (int ph = 0; ph < 12; ph++) begin
			wait_drained();
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			if (ph == 0 || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 5))
					0: vol_data = 8'h00;
					1: vol_data = 8'h7F;
					2: vol_data = 8'd100;
					default: vol_data = 8'($urandom_range(0, 255));
				endcase
				write_reg(CFG_VOLUME, vol_data);
			end
			if (ph == 0 || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 5))
					0: pan_data = 8'h00;
					1: pan_data = 8'd100;
					2: pan_data = 8'h9C;
					default: pan_data = 8'($urandom_range(0, 255));
				endcase
				write_reg(CFG_PAN, pan_data);
			end
			if (ph == 0 || $urandom_range(0, 2) == 0) begin
				write_reg(CFG_MUTED, {7'($urandom()), ($urandom_range(0, 5) == 0)});
			end
			if ($urandom_range(0, 7) == 0) begin
				write_reg(CFG_SPARE, 8'($urandom()));
			end
			run_phase(65);
		end

		// drain and report
		wait_drained();
		repeat (8) @(posedge clk);
		if (meter_sb.error_count == 0 && meter_sb.expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
